// ===== hw/rtl/dpsm_pkg.sv =====
`default_nettype none

package dpsm_pkg;

  // Field widths
  localparam int unsigned PressW = 13;
  localparam int unsigned ThrW   = 12;
  localparam int unsigned CntW   = 8;
  localparam int unsigned CfgW   = 12;
  localparam int unsigned AddrW  = 3;

  // Stream word widths
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 16;

  // Upper range bound, 200.0 mmHg in tenths
  localparam logic [ThrW-1:0] RangeMax = 12'd2000;

  // Configuration register indexes
  typedef enum logic [AddrW-1:0] {
    RegMaxPressure   = 3'd0,
    RegWarnThreshold = 3'd1,
    RegCheckInterval = 3'd2,
    RegSafetyEnable  = 3'd3,
    RegInvalidLimit  = 3'd4,
    RegErrorLimit    = 3'd5
  } cfg_reg_e;

  // Configuration set seen by the datapath
  typedef struct packed {
    logic [ThrW-1:0] max_pressure;
    logic [ThrW-1:0] warning_threshold;
    logic [CntW-1:0] check_interval;
    logic            safety_enable;
    logic [CntW-1:0] invalid_sample_limit;
    logic [CntW-1:0] safety_error_limit;
  } cfg_t;

  // One input sample
  typedef struct packed {
    logic              hardware_ready;
    logic              sensor_fault;
    logic [PressW-1:0] tank_pressure;
    logic [PressW-1:0] line_pressure;
  } item_t;

  // One result word
  typedef struct packed {
    logic stop_request;
    logic emergency_stop;
    logic not_ready_warning;
    logic range_warning;
    logic tank_warning;
    logic tank_alarm;
    logic line_warning;
    logic line_alarm;
    logic check_done;
    logic sample_valid;
  } res_t;

  // Saturating increment of an 8 bit counter
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
    sat_inc = (c == {CntW{1'b1}}) ? c : c + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dpsm_cfg_regs.sv =====
`default_nettype none

module dpsm_cfg_regs
  import dpsm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [AddrW-1:0] cfg_addr_i,
  input  wire logic [CfgW-1:0]  cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write into the addressed register
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegMaxPressure:   cfg_d.max_pressure         = cfg_wdata_i[ThrW-1:0];
        RegWarnThreshold: cfg_d.warning_threshold    = cfg_wdata_i[ThrW-1:0];
        RegCheckInterval: cfg_d.check_interval       = cfg_wdata_i[CntW-1:0];
        RegSafetyEnable:  cfg_d.safety_enable        = cfg_wdata_i[0];
        RegInvalidLimit:  cfg_d.invalid_sample_limit = cfg_wdata_i[CntW-1:0];
        RegErrorLimit:    cfg_d.safety_error_limit   = cfg_wdata_i[CntW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_pressure         <= 12'd1000;
      cfg_q.warning_threshold    <= 12'd800;
      cfg_q.check_interval       <= 8'd1;
      cfg_q.safety_enable        <= 1'b1;
      cfg_q.invalid_sample_limit <= 8'd10;
      cfg_q.safety_error_limit   <= 8'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dpsm_check.sv =====
`default_nettype none

module dpsm_check
  import dpsm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  wire item_t item_i,
  input  wire cfg_t  cfg_i,
  output res_t       res_o
);

  logic [CntW-1:0] interval_q, interval_d;
  logic [CntW-1:0] err_q, err_d;
  logic [CntW-1:0] inv_q, inv_d;

  logic            valid;
  logic            check;
  logic [CntW-1:0] interval_inc;
  logic [CntW-1:0] inv_inc;
  logic [CntW-1:0] err_rng;
  logic [ThrW-1:0] line_mag;
  logic [ThrW-1:0] tank_mag;

  // Evaluate one sample against the current counters
  always_comb begin
    valid    = !item_i.sensor_fault && !item_i.line_pressure[PressW-1]
               && !item_i.tank_pressure[PressW-1];
    line_mag = item_i.line_pressure[ThrW-1:0];
    tank_mag = item_i.tank_pressure[ThrW-1:0];

    interval_inc = sat_inc(interval_q);
    inv_inc      = sat_inc(inv_q);
    check        = valid && cfg_i.safety_enable
                   && (interval_inc >= cfg_i.check_interval);

    interval_d = interval_q;
    err_d      = err_q;
    inv_d      = valid ? '0 : inv_inc;
    res_o      = '0;

    res_o.sample_valid = valid;
    res_o.stop_request = !valid && (inv_inc >= cfg_i.invalid_sample_limit);

    if (valid && cfg_i.safety_enable) begin
      interval_d = check ? '0 : interval_inc;
    end

    if (check) begin
      res_o.check_done        = 1'b1;
      res_o.line_alarm        = line_mag > cfg_i.max_pressure;
      res_o.line_warning      = !res_o.line_alarm && (line_mag > cfg_i.warning_threshold);
      res_o.tank_alarm        = tank_mag > cfg_i.max_pressure;
      res_o.tank_warning      = !res_o.tank_alarm && (tank_mag > cfg_i.warning_threshold);
      res_o.range_warning     = (line_mag > RangeMax) || (tank_mag > RangeMax);
      res_o.not_ready_warning = !item_i.hardware_ready;
      err_rng                 = res_o.range_warning ? sat_inc(err_q) : '0;
      err_d                   = res_o.not_ready_warning ? sat_inc(err_rng) : err_rng;
      res_o.emergency_stop    = err_d >= cfg_i.safety_error_limit;
    end else begin
      err_rng = err_q;
    end
  end

  // Advance the counters once per processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
      err_q      <= '0;
      inv_q      <= '0;
    end else if (step_i) begin
      interval_q <= interval_d;
      err_q      <= err_d;
      inv_q      <= inv_d;
    end
  end

`ifndef SYNTHESIS
  a_valid_clears_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.sample_valid |=> inv_q == '0)
    else $error("invalid run not cleared by valid sample");

  a_invalid_holds_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !res_o.sample_valid |=> $stable(interval_q))
    else $error("interval count moved on invalid sample");

  a_check_restarts_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.check_done |=> interval_q == '0)
    else $error("interval count not restarted after check");

  a_estop_needs_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.emergency_stop |-> res_o.check_done && res_o.sample_valid)
    else $error("emergency stop without a check");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/dual_pressure_safety_monitor_unit.sv =====
`default_nettype none

// Dual pressure safety monitor. Each input word carries two signed pressure
// readings in tenths of mmHg plus a sensor fault flag and a hardware ready
// flag; each accepted word yields exactly one result word with the validity,
// check, alarm, warning and stop flags. Words pass through an input register
// and a result register with one level of logic in between, so the block
// takes one word per cycle while the result stream does not stall. Write the
// configuration registers only while no word is in flight.
module dual_pressure_safety_monitor_unit
  import dpsm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Sample stream
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [12:0] line_pressure, [25:13] tank_pressure, [26] sensor_fault,
  // [27] hardware_ready, [31:28] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // Result stream
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [0] sample_valid, [1] check_done, [2] line_alarm, [3] line_warning,
  // [4] tank_alarm, [5] tank_warning, [6] range_warning,
  // [7] not_ready_warning, [8] emergency_stop, [9] stop_request, [15:10] zero
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  // Configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [AddrW-1:0]    cfg_addr_i,
  input  wire logic [CfgW-1:0]     cfg_wdata_i
);

  cfg_t  cfg;
  item_t item_q;
  logic  in_vld_q;
  res_t  res, res_q;
  logic  out_vld_q;
  logic  step;
  logic  take;

  dpsm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Move a word forward when the result slot is free or being drained
  assign step            = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || step;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  dpsm_check u_check (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.line_pressure  <= s_axis_tdata_i[12:0];
      item_q.tank_pressure  <= s_axis_tdata_i[25:13];
      item_q.sensor_fault   <= s_axis_tdata_i[26];
      item_q.hardware_ready <= s_axis_tdata_i[27];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OutDataW - $bits(res_t)){1'b0}}, res_q};

endmodule

`default_nettype wire
